@@ rtl/mis_pkg.sv @@
// package: widths, capacity and shared types of the merge insertion sorter
`default_nettype none

package mis_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int VALUE_W   = 31;

  typedef logic [VALUE_W-1:0] value_t;

  // broadcast command seen by every cell
  typedef struct packed {
    logic   insert;
    logic   shift_dn;
    value_t value;
  } cell_cmd_t;

  // what a cell shows to its neighbours
  typedef struct packed {
    logic   occ;
    logic   gt;
    value_t value;
  } cell_link_t;

  typedef enum logic [1:0] {
    ST_COLLECT = 2'b01,
    ST_DRAIN   = 2'b10
  } state_t;

endpackage

`default_nettype wire

@@ rtl/mis_in_if.sv @@
// interface: input request channel (value and last flag)
`default_nettype none

interface mis_in_if import mis_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t value;
  logic   last_in;

  modport source (output valid, output value, output last_in, input ready);
  modport sink   (input valid, input value, input last_in, output ready);
endinterface

`default_nettype wire

@@ rtl/mis_out_if.sv @@
// interface: result request channel (sorted value, last and overflow flags)
`default_nettype none

interface mis_out_if import mis_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t sorted_value;
  logic   last_out;
  logic   overflow;

  modport source (output valid, output sorted_value, output last_out, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_out, input overflow,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/merge_insertion_sorter.sv @@
// Sorter top level: takes one value per cycle while collecting into an insertion chain of MAX_ITEMS cells.
// Input: one item per cycle while collecting; the chain compares all cells in parallel.
// Output: first result in the cycle after the last item is taken; then one result per cycle
// while out_chan.ready is high, shifted down the chain; no input is taken meanwhile.
// Reset (synchronous, rst_n low): chain empty, overflow flag clear, collecting.
`default_nettype none

module merge_insertion_sorter import mis_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  mis_in_if.sink    in_chan,
  mis_out_if.source out_chan
);

  state_t     state_r, state_nxt;
  logic       dropped_r, dropped_nxt;
  cell_cmd_t  cmd;
  cell_link_t link [MAX_ITEMS];
  cell_link_t head_link;
  cell_link_t tail_link;
  logic       in_acc;
  logic       out_acc;
  logic       full;

  assign full    = link[MAX_ITEMS-1].occ;
  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_chan.valid && out_chan.ready;

  assign cmd.insert   = in_acc && !full;
  assign cmd.shift_dn = out_acc;
  assign cmd.value    = in_chan.value;

  assign head_link.occ   = 1'b1;
  assign head_link.gt    = 1'b0;
  assign head_link.value = '0;
  assign tail_link.occ   = 1'b0;
  assign tail_link.gt    = 1'b0;
  assign tail_link.value = '0;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    cell_link_t prev_l, next_l;
    if (i == 0) begin : g_first
      assign prev_l = head_link;
    end else begin : g_mid_p
      assign prev_l = link[i-1];
    end
    if (i == MAX_ITEMS-1) begin : g_last
      assign next_l = tail_link;
    end else begin : g_mid_n
      assign next_l = link[i+1];
    end
    mis_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .cmd  (cmd),
      .prev (prev_l),
      .next (next_l),
      .self (link[i])
    );
  end

  always_comb begin
    state_nxt   = state_r;
    dropped_nxt = dropped_r;
    unique case (state_r)
      ST_COLLECT: begin
        if (in_acc) begin
          if (full) begin
            dropped_nxt = 1'b1;
          end
          if (in_chan.last_in) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_acc && !link[1].occ) begin
          state_nxt   = ST_COLLECT;
          dropped_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt   = ST_COLLECT;
        dropped_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_COLLECT;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  assign in_chan.ready         = (state_r == ST_COLLECT);
  assign out_chan.valid        = (state_r == ST_DRAIN) && link[0].occ;
  assign out_chan.sorted_value = link[0].value;
  assign out_chan.last_out     = !link[1].occ;
  assign out_chan.overflow     = dropped_r;

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_chan.ready && out_chan.valid))
    else $error("input and output active together");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> link[0].occ)
    else $error("draining an empty chain");

  a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.last_in) |=> (state_r == ST_DRAIN))
    else $error("last request did not start drain");

  a_drain_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_chan.last_out) |=> (in_chan.ready && !link[0].occ && !dropped_r))
    else $error("chain not empty after final result");
`endif

endmodule

`default_nettype wire

@@ rtl/mis_cell.sv @@
// module: one insertion cell of the sorting chain
`default_nettype none

module mis_cell import mis_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_cmd_t  cmd,
  input  cell_link_t prev,
  input  cell_link_t next,
  output cell_link_t self
);

  logic   occ_r, occ_nxt;
  value_t val_r, val_nxt;
  logic   gt;
  logic   ins_point;

  assign gt        = occ_r && (val_r > cmd.value);
  assign ins_point = !prev.gt && prev.occ && (gt || !occ_r);

  always_comb begin
    occ_nxt = occ_r;
    val_nxt = val_r;
    if (cmd.insert) begin
      occ_nxt = occ_r | prev.occ;
      if (prev.gt) begin
        val_nxt = prev.value;
      end else if (ins_point) begin
        val_nxt = cmd.value;
      end
    end else if (cmd.shift_dn) begin
      occ_nxt = next.occ;
      val_nxt = next.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign self.occ   = occ_r;
  assign self.gt    = gt;
  assign self.value = val_r;

endmodule

`default_nettype wire

@@ tb/sv/merge_insertion_sorter_test.sv @@
// testbench: drives value sets into merge_insertion_sorter and checks the ascending output
module merge_insertion_sorter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mis_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 200;

  typedef enum int {
    PICK_ANY,
    PICK_NARROW,
    PICK_EXTREME,
    PICK_RISING,
    PICK_FALLING
  } pick_t;

  typedef struct {
    value_t sorted_value;
    logic   last_out;
    logic   overflow;
  } sorted_t;

  class sort_scoreboard;
    value_t      held[MAX_ITEMS];
    int unsigned held_count;
    bit          dropped;
    sorted_t     sorted_q[$];
    int unsigned errors;

    function void note_request(value_t v, logic last);
      int unsigned pos;
      sorted_t     res;
      if (held_count >= MAX_ITEMS) begin
        dropped = 1'b1;
      end else begin
        pos = held_count;
        while (pos > 0 && held[pos-1] > v) begin
          held[pos] = held[pos-1];
          pos--;
        end
        held[pos] = v;
        held_count++;
      end
      if (last) begin
        for (int unsigned k = 0; k < held_count; k++) begin
          res.sorted_value = held[k];
          res.last_out     = (k + 1 == held_count);
          res.overflow     = dropped;
          sorted_q         = {sorted_q, res};
        end
        held_count = 0;
        dropped    = 1'b0;
      end
    endfunction

    function void check_result(value_t v, logic last, logic ovf);
      sorted_t want;
      if (sorted_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual value %0d last %0b overflow %0b",
                 $time, v, last, ovf);
        errors++;
        return;
      end
      want = sorted_q.pop_front();
      if (v !== want.sorted_value) begin
        $display("%0t: sorted_value mismatch: expected %0d, actual %0d",
                 $time, want.sorted_value, v);
        errors++;
      end
      if (last !== want.last_out) begin
        $display("%0t: last_out mismatch: expected %0b, actual %0b", $time, want.last_out, last);
        errors++;
      end
      if (ovf !== want.overflow) begin
        $display("%0t: overflow mismatch: expected %0b, actual %0b", $time, want.overflow, ovf);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   steady;
  int   cycles;

  mis_in_if  in_chan();
  mis_out_if out_chan();

  merge_insertion_sorter uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  sort_scoreboard sb = new;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // accepted requests on both channels
  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready)
      sb.note_request(in_chan.value, in_chan.last_in);
    if (rst_n && out_chan.valid && out_chan.ready)
      sb.check_result(out_chan.sorted_value, out_chan.last_out, out_chan.overflow);
  end

  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_chan.ready <= rst_n && (steady || $urandom_range(99) >= 15);
    end
  end

  task automatic send_request(value_t v, logic last);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 15) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.value   <= v;
    in_chan.last_in <= last;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic send_set(int n, pick_t pick);
    value_t v;
    value_t step;
    v    = value_t'($urandom());
    step = value_t'($urandom_range(1, 1000));
    for (int i = 0; i < n; i++) begin
      case (pick)
        PICK_NARROW:  v = value_t'($urandom_range(7));
        PICK_EXTREME: v = $urandom_range(1) ? {VALUE_W{1'b1}} - value_t'($urandom_range(3))
                                            : value_t'($urandom_range(3));
        PICK_RISING:  v = (i == 0) ? v : v + step;
        PICK_FALLING: v = (i == 0) ? v : v - step;
        default:      v = value_t'($urandom());
      endcase
      send_request(v, i == n - 1);
    end
  endtask

  initial begin
    int    sent;
    int    set_idx;
    int    n;
    pick_t pick;
    rst_n           = 1'b0;
    steady          = 1'b0;
    in_chan.valid   = 1'b0;
    in_chan.value   = '0;
    in_chan.last_in = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // single values at both ends, a pair, duplicates, falling run, bit patterns
    send_request('0, 1'b1);
    send_request({VALUE_W{1'b1}}, 1'b1);
    send_request({VALUE_W{1'b1}}, 1'b0);
    send_request('0, 1'b1);
    repeat (2) send_request(value_t'(5), 1'b0);
    send_request(value_t'(5), 1'b1);
    for (int i = 9; i >= 0; i--)
      send_request(value_t'(i), i == 0);
    send_request('0, 1'b0);
    send_request({VALUE_W{1'b1}}, 1'b0);
    send_request('0, 1'b0);
    send_request({VALUE_W{1'b1}}, 1'b1);
    send_request(31'h2AAA_AAAA, 1'b0);
    send_request(31'h5555_5555, 1'b1);

    // random sets, one filling the store exactly and one running past it
    sent    = 0;
    set_idx = 0;
    while (sent < RANDOM_ITEMS) begin
      steady = (set_idx >= 4 && set_idx <= 8);
      if (set_idx == 2)
        n = MAX_ITEMS;
      else if (set_idx == 6)
        n = MAX_ITEMS + 1 + $urandom_range(3);
      else
        n = $urandom_range(1, 12);
      pick = pick_t'($urandom_range(PICK_FALLING));
      send_set(n, pick);
      sent += n;
      set_idx++;
    end
    steady = 1'b0;
    @(negedge clk);
    in_chan.valid <= 1'b0;

    while (sb.sorted_q.size() != 0)
      @(posedge clk);
    repeat (MAX_ITEMS + 16) @(posedge clk);
    if (sb.errors == 0 && sb.sorted_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule

@@ merge_insertion_sorter.f @@
rtl/mis_pkg.sv
rtl/mis_in_if.sv
rtl/mis_out_if.sv
rtl/mis_cell.sv
rtl/merge_insertion_sorter.sv
tb/sv/merge_insertion_sorter_test.sv
